// ----- rtl/cfe_pkg.sv -----
package cfe_pkg;

    // Default bound on payload bytes per frame
    localparam int MAX_FRAME_DEF = 32;

    // Fixed byte values of the encoding
    localparam logic [7:0] DELIM_BYTE = 8'h00;
    localparam logic [7:0] ZERO_BYTE  = 8'h00;

    // Reset value of the delimiter enable
    localparam logic APPEND_DELIM_RST = 1'b1;

endpackage

// ----- rtl/cfe_group_mem.sv -----
module cfe_group_mem
    import cfe_pkg::*;
#(
    parameter int DEPTH  = MAX_FRAME_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [7:0]        o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/cfe_ctrl.sv -----
module cfe_ctrl
    import cfe_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF,
    parameter int ADDR_W    = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_append_delim,
    // input word
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_data_byte,
    input  logic              i_is_last,
    // output word
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_out_byte,
    output logic              o_out_last,
    output logic              o_overflow,
    // group buffer
    output logic              o_mem_we,
    output logic [ADDR_W-1:0] o_mem_waddr,
    output logic [7:0]        o_mem_wdata,
    output logic              o_mem_re,
    output logic [ADDR_W-1:0] o_mem_raddr,
    input  logic [7:0]        i_mem_rdata
);

    localparam int CNT_W = $clog2(MAX_FRAME + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CODE,
        S_READ,
        S_DATA,
        S_DELIM
    } t_state;

    t_state            r_state,     n_state;
    logic [CNT_W-1:0]  r_frame_cnt, n_frame_cnt;
    logic [CNT_W-1:0]  r_grp_cnt,   n_grp_cnt;
    logic              r_ovf_seen,  n_ovf_seen;
    logic [ADDR_W-1:0] r_idx,       n_idx;
    logic              r_close,     n_close;
    logic              r_again,     n_again;
    logic              r_out_valid, n_out_valid;
    logic [7:0]        r_out_byte,  n_out_byte;
    logic              r_out_last,  n_out_last;
    logic              r_out_ovf,   n_out_ovf;

    logic in_acc;
    logic room;
    logic is_zero;
    logic out_free;
    logic last_elem;
    logic final_grp;
    logic grp_done;
    logic frame_done;

    assign in_acc    = i_in_valid && (r_state == S_IDLE);
    assign room      = r_frame_cnt < CNT_W'(MAX_FRAME);
    assign is_zero   = i_data_byte == ZERO_BYTE;
    assign out_free  = !r_out_valid || i_out_ready;
    assign last_elem = CNT_W'(r_idx) == (r_grp_cnt - CNT_W'(1));
    // group whose last word closes the frame (no second flush, no delimiter)
    assign final_grp = r_close && !r_again && !i_append_delim;

    // Next-state logic
    always_comb begin
        n_state     = r_state;
        n_frame_cnt = r_frame_cnt;
        n_grp_cnt   = r_grp_cnt;
        n_ovf_seen  = r_ovf_seen;
        n_idx       = r_idx;
        n_close     = r_close;
        n_again     = r_again;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;
        o_mem_we    = 1'b0;
        o_mem_re    = 1'b0;
        grp_done    = 1'b0;
        frame_done  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (room) begin
                        n_frame_cnt = r_frame_cnt + CNT_W'(1);
                        if (!is_zero) begin
                            if (r_grp_cnt < CNT_W'(MAX_FRAME)) begin
                                o_mem_we  = 1'b1;
                                n_grp_cnt = r_grp_cnt + CNT_W'(1);
                            end else begin
                                n_ovf_seen = 1'b1;
                            end
                        end else begin
                            // zero byte: flush, and flush again if it ends the frame
                            n_state = S_CODE;
                            n_close = i_is_last;
                            n_again = i_is_last;
                        end
                    end else begin
                        n_ovf_seen = 1'b1;
                    end
                    if (i_is_last && !(room && is_zero)) begin
                        n_state = S_CODE;
                        n_close = 1'b1;
                        n_again = 1'b0;
                    end
                end
            end
            S_CODE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = 8'(r_grp_cnt) + 8'd1;
                    n_out_last  = final_grp && (r_grp_cnt == '0);
                    n_out_ovf   = final_grp && (r_grp_cnt == '0) && r_ovf_seen;
                    if (r_grp_cnt == '0) begin
                        grp_done = 1'b1;
                    end else begin
                        n_idx   = '0;
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                o_mem_re = 1'b1;
                n_state  = S_DATA;
            end
            S_DATA: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = i_mem_rdata;
                    n_out_last  = final_grp && last_elem;
                    n_out_ovf   = final_grp && last_elem && r_ovf_seen;
                    if (last_elem) begin
                        grp_done = 1'b1;
                    end else begin
                        n_idx   = r_idx + ADDR_W'(1);
                        n_state = S_READ;
                    end
                end
            end
            S_DELIM: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = DELIM_BYTE;
                    n_out_last  = 1'b1;
                    n_out_ovf   = r_ovf_seen;
                    frame_done  = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // End of a group flush
        if (grp_done) begin
            n_grp_cnt = '0;
            priority if (r_again) begin
                n_again = 1'b0;
                n_state = S_CODE;
            end else if (r_close && i_append_delim) begin
                n_state = S_DELIM;
            end else if (r_close) begin
                frame_done = 1'b1;
            end else begin
                n_state = S_IDLE;
            end
        end

        // End of a frame
        if (frame_done) begin
            n_frame_cnt = '0;
            n_ovf_seen  = 1'b0;
            n_grp_cnt   = '0;
            n_close     = 1'b0;
            n_state     = S_IDLE;
        end
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_frame_cnt <= '0;
            r_grp_cnt   <= '0;
            r_ovf_seen  <= 1'b0;
            r_close     <= 1'b0;
            r_again     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_frame_cnt <= n_frame_cnt;
            r_grp_cnt   <= n_grp_cnt;
            r_ovf_seen  <= n_ovf_seen;
            r_close     <= n_close;
            r_again     <= n_again;
            r_out_valid <= n_out_valid;
        end
        r_idx      <= n_idx;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
        r_out_ovf  <= n_out_ovf;
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_mem_waddr = r_grp_cnt[ADDR_W-1:0];
    assign o_mem_wdata = i_data_byte;
    assign o_mem_raddr = r_idx;
    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;
    assign o_overflow  = r_out_ovf;

endmodule

// ----- rtl/cobs_frame_encoder_top.sv -----
// Streaming COBS frame encoder. Payload words enter one per handshake with an
// end-of-frame mark; nonzero bytes go into a group buffer memory, and a zero byte
// or the frame end sends out the code byte (held count plus one) and then the
// held bytes, plus a closing 0x01 code when the frame ends on a zero and a 0x00
// delimiter when append_delimiter is set. A nonzero byte that does not end its
// frame is only written into the buffer. A flush sends the code byte, then reads
// each held byte through the single read port of the buffer, which is registered,
// before it is loaded into the output register. No input is taken while a flush
// runs. Bytes beyond MAX_FRAME in one frame are dropped and flagged on the
// frame's final output word.
module cobs_frame_encoder_top
    import cfe_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_is_last,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_out_last,
    output logic       o_overflow
);

    localparam int ADDR_W = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;

    logic              r_append_delim;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [7:0]        mem_rdata;
    logic              in_acc;

    // Delimiter enable register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_append_delim <= APPEND_DELIM_RST;
        end else if (i_cfg_we) begin
            r_append_delim <= i_cfg_wdata;
        end
    end

    cfe_ctrl #(
        .MAX_FRAME (MAX_FRAME),
        .ADDR_W    (ADDR_W)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_append_delim (r_append_delim),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_data_byte    (i_data_byte),
        .i_is_last      (i_is_last),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_byte     (o_out_byte),
        .o_out_last     (o_out_last),
        .o_overflow     (o_overflow),
        .o_mem_we       (mem_we),
        .o_mem_waddr    (mem_waddr),
        .o_mem_wdata    (mem_wdata),
        .o_mem_re       (mem_re),
        .o_mem_raddr    (mem_raddr),
        .i_mem_rdata    (mem_rdata)
    );

    cfe_group_mem #(
        .DEPTH  (MAX_FRAME),
        .ADDR_W (ADDR_W)
    ) u_group_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign in_acc = i_in_valid && o_in_ready;

    // Overflow is only reported on a frame's final word
    a_ovf_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_overflow |-> o_out_last)
        else $error("overflow flag on a word that does not end the frame");

    // Buffer is never written and read in the same cycle
    a_mem_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_re))
        else $error("group buffer write overlaps a read");

    // Buffer writes come only from accepted input words
    a_we_on_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> in_acc)
        else $error("group buffer written without an accepted word");

    // A frame end always starts a flush, which blocks input
    a_last_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_is_last |=> !o_in_ready)
        else $error("frame end did not start a flush");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import cfe_pkg::*;

    localparam int MAX_FRAME = MAX_FRAME_DEF;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int MAX_REPORTS = 60;

    // One raw payload word and one encoded output word
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_raw_word;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
        logic       ovf;
    } t_enc_word;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_wdata = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_is_last = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_out_last;
    logic       o_overflow;

    t_raw_word  raw_feed_q[$];
    t_enc_word  enc_expect_q[$];
    int         mismatch_cnt = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;

    // Long receiver hold-off, owned by its own counter
    logic       hold_start = 1'b0;
    logic       hold_armed = 1'b0;
    int         hold_left = 0;

    // Encoder shadow state
    logic [7:0] grp_buf [MAX_FRAME];
    logic [5:0] grp_cnt = '0;
    logic [5:0] frm_cnt = '0;
    logic       ovf_seen = 1'b0;
    logic       delim_on = APPEND_DELIM_RST;

    cobs_frame_encoder_top #(.MAX_FRAME(MAX_FRAME)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_byte (i_data_byte),
        .i_is_last   (i_is_last),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last),
        .o_overflow  (o_overflow)
    );

    always #6 i_clk = ~i_clk;

    task automatic note_mismatch(input string msg);
        if (mismatch_cnt < MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        mismatch_cnt++;
    endtask

    // Code byte (held count plus one), then the held bytes
    function automatic void flush_group();
        t_enc_word w;
        w.code = 8'(grp_cnt) + 8'd1;
        w.last = 1'b0;
        w.ovf  = 1'b0;
        enc_expect_q.push_back(w);
        for (int i = 0; i < int'(grp_cnt); i++) begin
            w.code = grp_buf[i];
            enc_expect_q.push_back(w);
        end
        grp_cnt = '0;
    endfunction

    // Expected encoded words for one accepted payload word
    function automatic void encode_byte(input logic [7:0] data, input logic last);
        t_enc_word w;
        if (int'(frm_cnt) < MAX_FRAME) begin
            frm_cnt++;
            if (data != ZERO_BYTE) begin
                if (int'(grp_cnt) < MAX_FRAME) begin
                    grp_buf[int'(grp_cnt)] = data;
                    grp_cnt++;
                end else begin
                    ovf_seen = 1'b1;
                end
            end else begin
                flush_group();
            end
        end else begin
            ovf_seen = 1'b1;
        end
        if (last) begin
            flush_group();
            if (delim_on) begin
                w.code = DELIM_BYTE;
                w.last = 1'b0;
                w.ovf  = 1'b0;
                enc_expect_q.push_back(w);
            end
            // frame flags ride on the final word
            w = enc_expect_q.pop_back();
            w.last = 1'b1;
            w.ovf  = ovf_seen;
            enc_expect_q.push_back(w);
            frm_cnt  = '0;
            grp_cnt  = '0;
            ovf_seen = 1'b0;
        end
    endfunction

    // Input driver: predicts on acceptance, then offers the next word or idles
    always @(posedge i_clk) begin : drive_in
        t_raw_word nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                encode_byte(i_data_byte, i_is_last);
            end
            if (!i_in_valid || o_in_ready) begin
                if (raw_feed_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = raw_feed_q.pop_front();
                    i_in_valid  <= 1'b1;
                    i_data_byte <= nxt.data;
                    i_is_last   <= nxt.last;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor and receiver stall
    always @(posedge i_clk) begin : watch_out
        t_enc_word want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (enc_expect_q.size() == 0) begin
                    note_mismatch($sformatf("unexpected word %02h last %0b ovf %0b",
                                            o_out_byte, o_out_last, o_overflow));
                end else begin
                    want = enc_expect_q.pop_front();
                    if (o_out_byte !== want.code)
                        note_mismatch($sformatf("byte %02h, want %02h", o_out_byte, want.code));
                    if (o_out_last !== want.last)
                        note_mismatch($sformatf("last %0b, want %0b on byte %02h",
                                                o_out_last, want.last, want.code));
                    if (o_overflow !== want.ovf)
                        note_mismatch($sformatf("overflow %0b, want %0b on byte %02h",
                                                o_overflow, want.ovf, want.code));
                end
            end
            i_out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Hold-off counter
    always @(posedge i_clk) begin
        if (hold_start && !hold_armed) begin
            hold_armed <= 1'b1;
            hold_left  <= HOLD_OFF_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    task automatic push_word(input logic [7:0] data, input logic last);
        t_raw_word w;
        w.data = data;
        w.last = last;
        raw_feed_q.push_back(w);
    endtask

    // One frame of random content; mostly short, some full or overlong
    task automatic queue_frame(output int len);
        int r;
        logic [7:0] b;
        r = $urandom_range(99);
        if (r < 15)
            len = $urandom_range(MAX_FRAME + 1, MAX_FRAME + 8);
        else if (r < 22)
            len = MAX_FRAME;
        else
            len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
            b = ($urandom_range(99) < 30) ? ZERO_BYTE : 8'($urandom_range(1, 255));
            push_word(b, i == len - 1);
        end
    endtask

    task automatic fill_random(input int n_words);
        int added;
        int len;
        added = 0;
        while (added < n_words) begin
            queue_frame(len);
            added += len;
        end
    endtask

    task automatic wait_drained();
        while (raw_feed_q.size() != 0 || i_in_valid || enc_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_delim(input logic v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        delim_on = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Run watchdog
    initial begin
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        for (int i = 0; i < MAX_FRAME; i++) grp_buf[i] = 8'h00;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames, no idling
        write_delim(1'b1);
        push_word(ZERO_BYTE, 1'b1);                 // lone zero
        push_word(8'h01, 1'b0);
        push_word(8'hFF, 1'b0);
        push_word(ZERO_BYTE, 1'b0);
        push_word(8'h80, 1'b1);
        push_word(8'h55, 1'b0);
        push_word(8'hAA, 1'b0);
        push_word(8'h7E, 1'b1);
        push_word(8'h11, 1'b0);                     // trailing zeros
        push_word(ZERO_BYTE, 1'b0);
        push_word(ZERO_BYTE, 1'b1);
        push_word(8'hFF, 1'b1);
        push_word(ZERO_BYTE, 1'b0);
        push_word(ZERO_BYTE, 1'b1);
        wait_drained();

        // Delimiter off, no idling
        write_delim(1'b0);
        push_word(8'h01, 1'b1);
        push_word(ZERO_BYTE, 1'b1);
        fill_random(68);
        wait_drained();

        // Delimiter on, sender idles
        write_delim(1'b1);
        send_idle_pct = 55;
        fill_random(68);
        wait_drained();

        // Delimiter off, receiver stalls
        write_delim(1'b0);
        send_idle_pct  = 0;
        recv_stall_pct = 55;
        fill_random(68);
        wait_drained();

        // Delimiter on, both sides idle, long hold-off to back up the input
        write_delim(1'b1);
        send_idle_pct  = 20;
        recv_stall_pct = 20;
        fill_random(68);
        @(posedge i_clk);
        hold_start <= 1'b1;
        wait_drained();

        if (mismatch_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
